>>> hw/rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam int HUE_W   = 15;
  localparam int CH_W    = 8;
  localparam int FRAC_W  = 12;
  localparam int SEC_W   = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic [HUE_W-1:0]  HUE_FULL_TURN = 15'd23040;
  localparam logic [FRAC_W-1:0] HUE_SECTOR    = 12'd3840;
  localparam logic [CH_W-1:0]   CH_MAX        = 8'hFF;

  // 255 * 3840, denominator of q and t
  localparam int LVL_W = 20;
  localparam logic [LVL_W-1:0] LVL_DEN = 20'd979200;

  // hue / 3840 == (hue >> 8) / 15, taken as (h * 137) >> 11 for h < 128
  localparam logic [7:0] SEC_RECIP = 8'd137;
  localparam int         SEC_SHIFT = 11;

  // x / 255 for 16-bit x: (x * 32897) >> 23, exact
  localparam logic [15:0] DIV255_RECIP = 16'd32897;
  localparam int          DIV255_SHIFT = 23;

  // y / 3825 for the 20-bit input y = x >> 8: (y * 1122868) >> 32, exact
  localparam logic [20:0] DEN_RECIP = 21'd1122868;
  localparam int          DEN_SHIFT = 32;

  // sector codes; five and above share the last ordering
  localparam logic [SEC_W-1:0] SEC_RED_YEL = 4'd0;
  localparam logic [SEC_W-1:0] SEC_YEL_GRN = 4'd1;
  localparam logic [SEC_W-1:0] SEC_GRN_CYN = 4'd2;
  localparam logic [SEC_W-1:0] SEC_CYN_BLU = 4'd3;
  localparam logic [SEC_W-1:0] SEC_BLU_MAG = 4'd4;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

endpackage

>>> hw/rtl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps

// Channel | Direction | Ports                      | Payload
// in      | slave     | in_tvalid/in_tready/in_tdata   | hue, saturation, brightness
// out     | master    | out_tvalid/out_tready/out_tdata | red, green, blue
//
// Five register stages: sector split, products, level scaling, divide by
// 255*3840, channel select into the output register.
// One request accepted per clock unless every stage is full and the output stalls.
// Each stage has its own valid bit and loads when it is empty or the stage
// after it is empty or moving, so bubbles close up under a stalled output.
// rst_n (synchronous, active low) clears the valid bits only.

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [14:0] hue, [22:15] saturation, [30:23] brightness, [31] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [HUE_W-1:0] in_hue;
  logic [CH_W-1:0]  in_sat;
  logic [CH_W-1:0]  in_val;

  assign in_hue = in_tdata[HUE_W-1:0];
  assign in_sat = in_tdata[HUE_W +: CH_W];
  assign in_val = in_tdata[HUE_W+CH_W +: CH_W];

  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic grey1_r, grey2_r, grey3_r, grey4_r;
  logic [SEC_W-1:0] sec1_r, sec2_r, sec3_r, sec4_r;
  logic [CH_W-1:0]  val1_r, val2_r, val3_r, val4_r;

  logic [FRAC_W-1:0] frac1_r;
  logic [CH_W-1:0]   sat1_r;
  logic [LVL_W-1:0]  sf2_r, sg2_r;
  logic [15:0]       pn2_r;
  logic [27:0]       qx3_r, tx3_r;
  logic [CH_W-1:0]   p3_r, p4_r, q4_r, t4_r;
  rgb_t              rgb_r;

  assign rdy5 = !v5_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_tready  = rdy1;
  assign out_tvalid = v5_r;
  assign out_tdata  = rgb_r;

  // stage 1: wrap a full turn to zero, split hue into sector and fraction
  logic [HUE_W-1:0]  hue_w;
  logic [HUE_W-1:0]  sec_prod;
  logic [SEC_W-1:0]  sec_nxt;
  logic [HUE_W-1:0]  sec_base;
  logic [HUE_W-1:0]  frac_full;

  always_comb begin
    hue_w     = (in_hue == HUE_FULL_TURN) ? '0 : in_hue;
    sec_prod  = HUE_W'(hue_w[HUE_W-1:8]) * HUE_W'(SEC_RECIP);
    sec_nxt   = sec_prod[SEC_SHIFT +: SEC_W];
    sec_base  = HUE_W'(sec_nxt) * HUE_W'(HUE_SECTOR);
    frac_full = hue_w - sec_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_tvalid;
    end
    if (rdy1) begin
      grey1_r <= (in_sat == '0);
      sec1_r  <= sec_nxt;
      frac1_r <= frac_full[FRAC_W-1:0];
      sat1_r  <= in_sat;
      val1_r  <= in_val;
    end
  end

  // stage 2: S*F, S*(3840-F), V*(255-S)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2) begin
      grey2_r <= grey1_r;
      sec2_r  <= sec1_r;
      val2_r  <= val1_r;
      sf2_r   <= LVL_W'(sat1_r) * LVL_W'(frac1_r);
      sg2_r   <= LVL_W'(sat1_r) * LVL_W'(HUE_SECTOR - frac1_r);
      pn2_r   <= 16'(val1_r) * 16'(CH_MAX - sat1_r);
    end
  end

  // stage 3: V times the q and t numerators, p by reciprocal of 255
  logic [31:0] p_prod;

  assign p_prod = 32'(pn2_r) * 32'(DIV255_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
    if (rdy3) begin
      grey3_r <= grey2_r;
      sec3_r  <= sec2_r;
      val3_r  <= val2_r;
      qx3_r   <= 28'(val2_r) * 28'(LVL_DEN - sf2_r);
      tx3_r   <= 28'(val2_r) * 28'(LVL_DEN - sg2_r);
      p3_r    <= p_prod[DIV255_SHIFT +: CH_W];
    end
  end

  // stage 4: divide by 255*3840 (drop 8 bits, then reciprocal of 3825)
  logic [40:0] q_prod, t_prod;

  assign q_prod = 41'(qx3_r[27:8]) * 41'(DEN_RECIP);
  assign t_prod = 41'(tx3_r[27:8]) * 41'(DEN_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
    if (rdy4) begin
      grey4_r <= grey3_r;
      sec4_r  <= sec3_r;
      val4_r  <= val3_r;
      p4_r    <= p3_r;
      q4_r    <= q_prod[DEN_SHIFT +: CH_W];
      t4_r    <= t_prod[DEN_SHIFT +: CH_W];
    end
  end

  // stage 5: channel order by sector, grey override
  rgb_t rgb_nxt;

  always_comb begin
    unique case (sec4_r)
      SEC_RED_YEL: rgb_nxt = '{blue: p4_r,   green: t4_r,   red: val4_r};
      SEC_YEL_GRN: rgb_nxt = '{blue: p4_r,   green: val4_r, red: q4_r};
      SEC_GRN_CYN: rgb_nxt = '{blue: t4_r,   green: val4_r, red: p4_r};
      SEC_CYN_BLU: rgb_nxt = '{blue: val4_r, green: q4_r,   red: p4_r};
      SEC_BLU_MAG: rgb_nxt = '{blue: val4_r, green: p4_r,   red: t4_r};
      default:     rgb_nxt = '{blue: q4_r,   green: p4_r,   red: val4_r};
    endcase
    if (grey4_r) begin
      rgb_nxt = '{blue: val4_r, green: val4_r, red: val4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= v4_r;
    end
    if (rdy5) begin
      rgb_r <= rgb_nxt;
    end
  end

endmodule

>>> hw/rtl/hsv2rgb_checker.sv
`timescale 1ns / 1ps

module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  // a held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an empty output register means the whole pipe can take a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // an accepted request reaches the output while the output side stays ready
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 out_tready ##1 out_tready ##1 out_tready ##1 out_tready
    |=> out_tvalid)
    else $error("result missing after five cycles");

  // zero saturation gives grey at the brightness
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tdata[HUE_W +: CH_W] == '0)
    ##1 out_tready ##1 out_tready ##1 out_tready ##1 out_tready
    |=> (out_tdata[7:0] == $past(in_tdata[HUE_W+CH_W +: CH_W], 5)) &&
        (out_tdata[15:8] == out_tdata[7:0]) &&
        (out_tdata[23:16] == out_tdata[7:0]))
    else $error("grey result wrong");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);
